// File: rtl/tilt_angle_kalman_filter_unit_assert.svh
// Assertion macros shared by the checker of the tilt angle Kalman filter unit.
`ifndef TILT_ANGLE_KALMAN_FILTER_UNIT_ASSERT_SVH
`define TILT_ANGLE_KALMAN_FILTER_UNIT_ASSERT_SVH

// Consequent checked in the same cycle as the antecedent.
`define TAKF_ASSERT_SAME(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Consequent checked in the cycle after the antecedent.
`define TAKF_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// File: rtl/takf_pkg.sv
// Shared widths, register codes, reset values, types and helpers of the Kalman filter unit.
package takf_pkg;

    localparam int DATA_W    = 32;
    localparam int OPND_W    = 34;
    localparam int PROD_W    = 64;
    localparam int RES_W     = 36;
    localparam int WIDE_W    = 40;
    localparam int CFG_IDX_W = 8;

    localparam logic [CFG_IDX_W-1:0] REG_SAMPLE_PERIOD = 8'd0;
    localparam logic [CFG_IDX_W-1:0] REG_ANGLE_NOISE   = 8'd1;
    localparam logic [CFG_IDX_W-1:0] REG_BIAS_NOISE    = 8'd2;
    localparam logic [CFG_IDX_W-1:0] REG_MEASURE_NOISE = 8'd3;

    localparam logic [DATA_W-1:0] RST_SAMPLE_PERIOD = 32'd4294967;
    localparam logic [DATA_W-1:0] RST_ANGLE_NOISE   = 32'd1073742;
    localparam logic [DATA_W-1:0] RST_BIAS_NOISE    = 32'd5368709;
    localparam logic [DATA_W-1:0] RST_MEASURE_NOISE = 32'd536870912;
    localparam logic signed [DATA_W-1:0] Q30_ONE    = 32'sh4000_0000;

    localparam logic signed [DATA_W-1:0] S32_MAX = 32'sh7FFF_FFFF;
    localparam logic signed [DATA_W-1:0] S32_MIN = 32'sh8000_0000;
    localparam logic signed [WIDE_W-1:0] S32_MAX_W = 40'sh00_7FFF_FFFF;
    localparam logic signed [WIDE_W-1:0] S32_MIN_W = 40'shFF_8000_0000;

    // Operands of one multiply: a * b, rounded and shifted right by 30 or 32.
    typedef struct packed {
        logic signed [OPND_W-1:0] a;
        logic signed [OPND_W-1:0] b;
        logic                     sh30;
    } mul_req_t;

    // Gain request: num * 2^30 / innov_var.
    typedef struct packed {
        logic                     start;
        logic signed [DATA_W-1:0] num;
        logic signed [OPND_W-1:0] innov_var;
    } div_req_t;

    typedef struct packed {
        logic                     done;
        logic signed [DATA_W-1:0] gain;
    } div_rsp_t;

    function automatic logic signed [WIDE_W-1:0] sx40(input logic signed [DATA_W-1:0] v);
        return {{(WIDE_W-DATA_W){v[DATA_W-1]}}, v};
    endfunction

    function automatic logic signed [WIDE_W-1:0] ux40(input logic [DATA_W-1:0] v);
        return {{(WIDE_W-DATA_W){1'b0}}, v};
    endfunction

    function automatic logic signed [WIDE_W-1:0] rx40(input logic signed [RES_W-1:0] v);
        return {{(WIDE_W-RES_W){v[RES_W-1]}}, v};
    endfunction

    function automatic logic signed [OPND_W-1:0] sx34(input logic signed [DATA_W-1:0] v);
        return {{(OPND_W-DATA_W){v[DATA_W-1]}}, v};
    endfunction

    function automatic logic signed [DATA_W-1:0] sat32(input logic signed [WIDE_W-1:0] v);
        logic signed [DATA_W-1:0] r;
        if (v > S32_MAX_W) begin
            r = S32_MAX;
        end else if (v < S32_MIN_W) begin
            r = S32_MIN;
        end else begin
            r = v[DATA_W-1:0];
        end
        return r;
    endfunction

endpackage

// File: rtl/takf_mul.sv
// Shared two-stage signed multiplier with round-half-away-from-zero and shift by 30 or 32.
module takf_mul (
    input  logic                                clk,
    input  takf_pkg::mul_req_t                  req,
    output logic signed [takf_pkg::RES_W-1:0]   res
);
    import takf_pkg::*;

    logic [OPND_W-1:0] a_abs;
    logic [OPND_W-1:0] b_abs;
    logic [DATA_W-1:0] a_mag;
    logic [DATA_W-1:0] b_mag;
    logic [PROD_W-1:0] prod_next;
    logic [PROD_W-1:0] prod_reg;
    logic              neg_reg;
    logic              sh30_reg;
    logic [PROD_W:0]   rnd;
    logic [OPND_W-1:0] mag;
    logic signed [RES_W-1:0] res_next;
    logic signed [RES_W-1:0] res_reg;

    // Magnitudes of all operands used by the filter fit in 32 bits.
    assign a_abs = req.a[OPND_W-1] ? OPND_W'(-req.a) : OPND_W'(req.a);
    assign b_abs = req.b[OPND_W-1] ? OPND_W'(-req.b) : OPND_W'(req.b);
    assign a_mag = a_abs[DATA_W-1:0];
    assign b_mag = b_abs[DATA_W-1:0];
    assign prod_next = a_mag * b_mag;

    always_ff @(posedge clk) begin
        prod_reg <= prod_next;
        neg_reg  <= req.a[OPND_W-1] ^ req.b[OPND_W-1];
        sh30_reg <= req.sh30;
    end

    always_comb begin
        rnd = {1'b0, prod_reg} + (sh30_reg ? 65'h0_0000_0000_2000_0000
                                           : 65'h0_0000_0000_8000_0000);
        mag = sh30_reg ? rnd[63:30] : {1'b0, rnd[64:32]};
        res_next = neg_reg ? -$signed({2'b00, mag}) : $signed({2'b00, mag});
    end

    always_ff @(posedge clk) begin
        res_reg <= res_next;
    end

    assign res = res_reg;

endmodule

// File: rtl/takf_div.sv
// Radix-2 restoring divider that forms one saturated Q2.30 gain, one quotient bit per cycle.
module takf_div (
    input  logic               clk,
    input  logic               rst_n,
    input  takf_pkg::div_req_t req,
    output takf_pkg::div_rsp_t rsp
);
    import takf_pkg::*;

    localparam logic [4:0] LAST_STEP = 5'd31;

    logic              busy_reg;
    logic              done_reg;
    logic [4:0]        cnt_reg;
    logic [32:0]       rem_reg;
    logic [32:0]       den_reg;
    logic [DATA_W-1:0] quo_reg;
    logic              neg_reg;
    logic              ovf_reg;

    logic [DATA_W-1:0] num_abs;
    logic              var_pos;
    logic              ovf_start;
    logic [33:0]       trial;
    logic [33:0]       diff;
    logic              qbit;
    logic [32:0]       rem_next;
    logic              sat;

    assign num_abs   = req.num[DATA_W-1] ? DATA_W'(-req.num) : DATA_W'(req.num);
    assign var_pos   = !req.innov_var[OPND_W-1] && (req.innov_var != '0);
    // The quotient reaches 2^32 exactly when the dividend's upper part is not below the divisor.
    assign ovf_start = {3'b000, num_abs[DATA_W-1:2]} >= req.innov_var[32:0];

    assign trial    = {rem_reg, quo_reg[DATA_W-1]};
    assign diff     = trial - {1'b0, den_reg};
    assign qbit     = trial >= {1'b0, den_reg};
    assign rem_next = qbit ? diff[32:0] : trial[32:0];

    always_ff @(posedge clk or negedge rst_n) begin
        if (!rst_n) begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end else if (req.start) begin
            cnt_reg  <= '0;
            busy_reg <= var_pos && !ovf_start;
            done_reg <= !var_pos || ovf_start;
        end else if (busy_reg) begin
            cnt_reg <= cnt_reg + 5'd1;
            if (cnt_reg == LAST_STEP) begin
                busy_reg <= 1'b0;
                done_reg <= 1'b1;
            end
        end else begin
            done_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk) begin
        if (req.start) begin
            neg_reg <= req.num[DATA_W-1];
            den_reg <= req.innov_var[32:0];
            rem_reg <= {3'b000, num_abs[DATA_W-1:2]};
            if (!var_pos) begin
                quo_reg <= '0;
                ovf_reg <= 1'b0;
            end else begin
                quo_reg <= {num_abs[1:0], 30'b0};
                ovf_reg <= ovf_start;
            end
        end else if (busy_reg) begin
            rem_reg <= rem_next;
            quo_reg <= {quo_reg[DATA_W-2:0], qbit};
        end
    end

    always_comb begin
        sat = ovf_reg || quo_reg[DATA_W-1];
        rsp.done = done_reg;
        if (sat) begin
            rsp.gain = neg_reg ? S32_MIN : S32_MAX;
        end else begin
            rsp.gain = neg_reg ? -$signed(quo_reg) : $signed(quo_reg);
        end
    end

endmodule

// File: rtl/tilt_angle_kalman_filter_unit.sv
// Top level of the one-axis tilt angle Kalman filter (angle and gyro bias states).
//
//  channel   direction  handshake                  payload
//  sample    in         sample_valid/sample_ready  measured_angle, gyro_rate (Q16.16)
//  result    out        result_valid/result_ready  filtered_angle, corrected_rate (Q16.16)
//  cfg       in         cfg_valid/cfg_ready        cfg_index, cfg_data
//
// A sample runs through prediction, two gain divisions, correction and the load of
// the result; only then, back in idle, is the next request taken. A division whose
// quotient reaches 2^32, or whose innovation variance is not positive, ends without
// stepping through the quotient bits.
// Reset is asynchronous and active low; it restores the register defaults and state.
// A stalled result holds the next load in the final state, and with it the input.
module tilt_angle_kalman_filter_unit (
    input  logic                                   clk,
    input  logic                                   rst_n,
    input  logic                                   sample_valid,
    output logic                                   sample_ready,
    input  logic signed [takf_pkg::DATA_W-1:0]     measured_angle,
    input  logic signed [takf_pkg::DATA_W-1:0]     gyro_rate,
    output logic                                   result_valid,
    input  logic                                   result_ready,
    output logic signed [takf_pkg::DATA_W-1:0]     filtered_angle,
    output logic signed [takf_pkg::DATA_W-1:0]     corrected_rate,
    input  logic                                   cfg_valid,
    output logic                                   cfg_ready,
    input  logic [takf_pkg::CFG_IDX_W-1:0]         cfg_index,
    input  logic [takf_pkg::DATA_W-1:0]            cfg_data
);
    import takf_pkg::*;

    // Sequencer states.
    localparam logic [2:0] ST_IDLE      = 3'd0;
    localparam logic [2:0] ST_PRED      = 3'd1;
    localparam logic [2:0] ST_DIV0_GO   = 3'd2;
    localparam logic [2:0] ST_DIV0_WAIT = 3'd3;
    localparam logic [2:0] ST_DIV1_GO   = 3'd4;
    localparam logic [2:0] ST_DIV1_WAIT = 3'd5;
    localparam logic [2:0] ST_UPD       = 3'd6;
    localparam logic [2:0] ST_FIN       = 3'd7;

    // Each phase runs on past its last issue until that product has come out of the
    // multiplier's product and result registers.
    localparam logic [2:0] PRED_LAST = 3'd5;
    localparam logic [2:0] UPD_LAST  = 3'd7;

    logic [2:0] state_reg;
    logic [2:0] state_next;
    logic [2:0] cnt_reg;
    logic [2:0] cnt_next;

    logic [DATA_W-1:0] sample_period_reg;
    logic [DATA_W-1:0] angle_noise_reg;
    logic [DATA_W-1:0] bias_noise_reg;
    logic [DATA_W-1:0] measure_noise_reg;

    logic signed [DATA_W-1:0] ang_reg;
    logic signed [DATA_W-1:0] bias_reg;
    logic signed [DATA_W-1:0] p00_reg;
    logic signed [DATA_W-1:0] p01_reg;
    logic signed [DATA_W-1:0] p10_reg;
    logic signed [DATA_W-1:0] p11_reg;

    logic signed [DATA_W-1:0] meas_reg;
    logic signed [DATA_W-1:0] gyro_reg;
    logic signed [DATA_W-1:0] k0_reg;
    logic signed [DATA_W-1:0] k1_reg;

    logic                     result_valid_reg;
    logic signed [DATA_W-1:0] filtered_reg;
    logic signed [DATA_W-1:0] corrected_reg;

    logic sample_acc;
    logic result_load;

    logic signed [OPND_W-1:0] rate;
    logic signed [OPND_W-1:0] err;
    logic signed [DATA_W-1:0] d0;
    logic signed [DATA_W-1:0] d1;
    logic signed [DATA_W-1:0] d3;

    mul_req_t                mreq;
    logic signed [RES_W-1:0] mres;
    div_req_t                dreq;
    div_rsp_t                drsp;

    takf_mul u_mul (
        .clk (clk),
        .req (mreq),
        .res (mres)
    );

    takf_div u_div (
        .clk   (clk),
        .rst_n (rst_n),
        .req   (dreq),
        .rsp   (drsp)
    );

    assign sample_ready = (state_reg == ST_IDLE);
    assign sample_acc   = sample_valid && sample_ready;
    assign cfg_ready    = 1'b1;
    // The final load goes ahead once the output register is free or being emptied.
    assign result_load  = (state_reg == ST_FIN) && (!result_valid_reg || result_ready);

    // Bias-corrected rate and innovation; both can exceed 32 bits.
    assign rate = sx34(gyro_reg) - sx34(bias_reg);
    assign err  = sx34(meas_reg) - sx34(ang_reg);

    // Covariance derivative terms, saturated before they are scaled by the period.
    assign d0 = sat32(ux40(angle_noise_reg) - sx40(p01_reg) - sx40(p10_reg));
    assign d1 = sat32(-sx40(p11_reg));
    assign d3 = sat32(ux40(bias_noise_reg));

    // Gain requests: the innovation variance is measure noise plus the predicted P00.
    always_comb
    begin
        dreq.start     = (state_reg == ST_DIV0_GO) || (state_reg == ST_DIV1_GO);
        dreq.num       = (state_reg == ST_DIV1_GO) ? p10_reg : p00_reg;
        dreq.innov_var = $signed({2'b00, measure_noise_reg}) + sx34(p00_reg);
    end

    // Multiplier issue schedule. Prediction scales by the sample period (shift 32),
    // correction scales by the gains (shift 30).
    always_comb
    begin
        mreq.a    = '0;
        mreq.b    = '0;
        mreq.sh30 = 1'b0;
        unique case (state_reg)
            ST_PRED:
            begin
                mreq.b = $signed({2'b00, sample_period_reg});
                case (cnt_reg)
                    3'd0:    mreq.a = rate;
                    3'd1:    mreq.a = sx34(d0);
                    3'd2:    mreq.a = sx34(d1);
                    3'd3:    mreq.a = sx34(d3);
                    default: mreq.a = '0;
                endcase
            end
            ST_UPD:
            begin
                mreq.sh30 = 1'b1;
                case (cnt_reg)
                    3'd0:
                    begin
                        mreq.a = sx34(k0_reg);
                        mreq.b = sx34(p00_reg);
                    end
                    3'd1:
                    begin
                        mreq.a = sx34(k0_reg);
                        mreq.b = sx34(p01_reg);
                    end
                    3'd2:
                    begin
                        mreq.a = sx34(k1_reg);
                        mreq.b = sx34(p00_reg);
                    end
                    3'd3:
                    begin
                        mreq.a = sx34(k1_reg);
                        mreq.b = sx34(p01_reg);
                    end
                    3'd4:
                    begin
                        mreq.a = sx34(k0_reg);
                        mreq.b = err;
                    end
                    3'd5:
                    begin
                        mreq.a = sx34(k1_reg);
                        mreq.b = err;
                    end
                    default:
                    begin
                        mreq.a = '0;
                        mreq.b = '0;
                    end
                endcase
            end
            ST_IDLE, ST_DIV0_GO, ST_DIV0_WAIT, ST_DIV1_GO, ST_DIV1_WAIT, ST_FIN:
            begin
                mreq.a = '0;
            end
            default:
            begin
                mreq.a = '0;
            end
        endcase
    end

    // Sequencer.
    always_comb
    begin
        state_next = state_reg;
        cnt_next   = cnt_reg;
        unique case (state_reg)
            ST_IDLE:
            begin
                cnt_next = '0;
                if (sample_valid)
                begin
                    state_next = ST_PRED;
                end
            end
            ST_PRED:
            begin
                cnt_next = cnt_reg + 3'd1;
                if (cnt_reg == PRED_LAST)
                begin
                    state_next = ST_DIV0_GO;
                    cnt_next   = '0;
                end
            end
            ST_DIV0_GO:
            begin
                state_next = ST_DIV0_WAIT;
            end
            ST_DIV0_WAIT:
            begin
                if (drsp.done)
                begin
                    state_next = ST_DIV1_GO;
                end
            end
            ST_DIV1_GO:
            begin
                state_next = ST_DIV1_WAIT;
            end
            ST_DIV1_WAIT:
            begin
                if (drsp.done)
                begin
                    state_next = ST_UPD;
                    cnt_next   = '0;
                end
            end
            ST_UPD:
            begin
                cnt_next = cnt_reg + 3'd1;
                if (cnt_reg == UPD_LAST)
                begin
                    state_next = ST_FIN;
                    cnt_next   = '0;
                end
            end
            ST_FIN:
            begin
                if (result_load)
                begin
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
                cnt_next   = '0;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
            cnt_reg   <= '0;
        end
        else
        begin
            state_reg <= state_next;
            cnt_reg   <= cnt_next;
        end
    end

    // Configuration registers and filter state. Each multiplier result is taken
    // after it has passed the multiplier's product and result registers.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            sample_period_reg <= RST_SAMPLE_PERIOD;
            angle_noise_reg   <= RST_ANGLE_NOISE;
            bias_noise_reg    <= RST_BIAS_NOISE;
            measure_noise_reg <= RST_MEASURE_NOISE;
            ang_reg           <= '0;
            bias_reg          <= '0;
            p00_reg           <= Q30_ONE;
            p01_reg           <= '0;
            p10_reg           <= '0;
            p11_reg           <= Q30_ONE;
        end
        else
        begin
            if (cfg_valid && cfg_ready)
            begin
                unique case (cfg_index)
                    REG_SAMPLE_PERIOD: sample_period_reg <= cfg_data;
                    REG_ANGLE_NOISE:   angle_noise_reg   <= cfg_data;
                    REG_BIAS_NOISE:    bias_noise_reg    <= cfg_data;
                    REG_MEASURE_NOISE: measure_noise_reg <= cfg_data;
                    default:
                    begin
                        sample_period_reg <= sample_period_reg;
                    end
                endcase
            end
            if (state_reg == ST_PRED)
            begin
                case (cnt_reg)
                    3'd2: ang_reg <= sat32(sx40(ang_reg) + rx40(mres));
                    3'd3: p00_reg <= sat32(sx40(p00_reg) + rx40(mres));
                    3'd4:
                    begin
                        // One product serves both off-diagonal terms.
                        p01_reg <= sat32(sx40(p01_reg) + rx40(mres));
                        p10_reg <= sat32(sx40(p10_reg) + rx40(mres));
                    end
                    3'd5: p11_reg <= sat32(sx40(p11_reg) + rx40(mres));
                    default:
                    begin
                        p11_reg <= p11_reg;
                    end
                endcase
            end
            if (state_reg == ST_UPD)
            begin
                case (cnt_reg)
                    3'd2: p00_reg  <= sat32(sx40(p00_reg) - rx40(mres));
                    3'd3: p01_reg  <= sat32(sx40(p01_reg) - rx40(mres));
                    3'd4: p10_reg  <= sat32(sx40(p10_reg) - rx40(mres));
                    3'd5: p11_reg  <= sat32(sx40(p11_reg) - rx40(mres));
                    3'd6: ang_reg  <= sat32(sx40(ang_reg) + rx40(mres));
                    3'd7: bias_reg <= sat32(sx40(bias_reg) + rx40(mres));
                    default:
                    begin
                        bias_reg <= bias_reg;
                    end
                endcase
            end
        end
    end

    // Sample capture and gains.
    always_ff @(posedge clk)
    begin
        if (sample_acc)
        begin
            meas_reg <= measured_angle;
            gyro_reg <= gyro_rate;
        end
        if ((state_reg == ST_DIV0_WAIT) && drsp.done)
        begin
            k0_reg <= drsp.gain;
        end
        if ((state_reg == ST_DIV1_WAIT) && drsp.done)
        begin
            k1_reg <= drsp.gain;
        end
    end

    // Output register.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            result_valid_reg <= 1'b0;
        end
        else if (result_load)
        begin
            result_valid_reg <= 1'b1;
        end
        else if (result_ready)
        begin
            result_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (result_load)
        begin
            filtered_reg  <= ang_reg;
            corrected_reg <= sat32(sx40(gyro_reg) - sx40(bias_reg));
        end
    end

    assign result_valid   = result_valid_reg;
    assign filtered_angle = filtered_reg;
    assign corrected_rate = corrected_reg;

endmodule

// File: rtl/takf_checker.sv
// Port-level checker of the tilt angle Kalman filter unit and its bind statement.
`include "tilt_angle_kalman_filter_unit_assert.svh"

module takf_checker (
    input  logic                                   clk,
    input  logic                                   rst_n,
    input  logic                                   sample_valid,
    input  logic                                   sample_ready,
    input  logic signed [takf_pkg::DATA_W-1:0]     measured_angle,
    input  logic signed [takf_pkg::DATA_W-1:0]     gyro_rate,
    input  logic                                   result_valid,
    input  logic                                   result_ready,
    input  logic signed [takf_pkg::DATA_W-1:0]     filtered_angle,
    input  logic signed [takf_pkg::DATA_W-1:0]     corrected_rate,
    input  logic                                   cfg_valid,
    input  logic                                   cfg_ready,
    input  logic [takf_pkg::CFG_IDX_W-1:0]         cfg_index,
    input  logic [takf_pkg::DATA_W-1:0]            cfg_data
);
    import takf_pkg::*;

    // A request occupies the unit, so no second sample is taken right behind it.
    `TAKF_ASSERT_NEXT(a_busy_after_accept, sample_valid && sample_ready, !sample_ready, "sample taken while busy")

    // The unit is still busy at the later check, since prediction has not ended by then.
    `TAKF_ASSERT_SAME(a_busy_two_later, sample_valid && sample_ready, ##2 !sample_ready, "request finished too early")

    // A new result appears only as the sequencer returns to idle.
    `TAKF_ASSERT_SAME(a_result_at_idle, $rose(result_valid), sample_ready, "result shown while busy")

    // A result that is not taken stays with its payload.
    `TAKF_ASSERT_NEXT(a_result_holds, result_valid && !result_ready, result_valid && $stable(filtered_angle) && $stable(corrected_rate), "stalled result changed")

endmodule

bind tilt_angle_kalman_filter_unit takf_checker u_takf_checker (.*);

// File: test/tb_tilt_angle_kalman_filter_unit.sv
// Self-checking testbench of the tilt angle Kalman filter unit against its own fixed-point filter.
module tb_tilt_angle_kalman_filter_unit;
    import takf_pkg::*;

    // Run shape. Every sample causes exactly one result, so the settle time after
    // the last result only has to cover the longest sample with margin.
    localparam int RESET_CYCLES    = 12;
    localparam int SETTLE_CYCLES   = 200;
    localparam int HOLD_CYCLES     = 1500;
    localparam int ITEMS_PER_PHASE = 103;
    localparam int NUM_PHASES      = 9;
    localparam int CYCLE_LIMIT     = 1000000;
    localparam int MAX_PRINTED     = 60;

    // Register indexes at and above REG_COUNT address nothing and must be ignored.
    localparam logic [CFG_IDX_W-1:0] REG_COUNT     = 8'd4;
    localparam logic [CFG_IDX_W-1:0] REG_INDEX_TOP = '1;

    // Handy Q16.16 values: 90 degrees and a 500 degrees per second rate span.
    localparam logic signed [DATA_W-1:0] DEG_90   = 32'sd5898240;
    localparam int                       DEG_ONE  = 65536;
    localparam int                       RATE_SPAN = 32768000;

    typedef struct packed {
        logic signed [DATA_W-1:0] angle;
        logic signed [DATA_W-1:0] rate;
    } sample_t;

    typedef struct packed {
        logic signed [DATA_W-1:0] filtered;
        logic signed [DATA_W-1:0] corrected;
    } result_t;

    // Clock, reset and all block inputs start at known values.
    logic                         clk            = 1'b0;
    logic                         rst_n          = 1'b0;
    logic                         sample_valid   = 1'b0;
    logic signed [DATA_W-1:0]     measured_angle = '0;
    logic signed [DATA_W-1:0]     gyro_rate      = '0;
    logic                         result_ready   = 1'b0;
    logic                         cfg_valid      = 1'b0;
    logic [CFG_IDX_W-1:0]         cfg_index      = '0;
    logic [DATA_W-1:0]            cfg_data       = '0;
    logic                         sample_ready;
    logic                         result_valid;
    logic signed [DATA_W-1:0]     filtered_angle;
    logic signed [DATA_W-1:0]     corrected_rate;
    logic                         cfg_ready;

    // Sample requests waiting to be offered, and the results the filter must produce.
    sample_t pending_samples[$];
    result_t expected_outputs[$];

    // Idle percentages of the two sides, and the long receiver hold-off.
    int   send_gap_pct   = 0;
    int   recv_stall_pct = 0;
    logic hold_request   = 1'b0;
    logic hold_active    = 1'b0;

    int   error_count     = 0;
    int   samples_sent    = 0;
    int   results_checked = 0;
    int   register_writes = 0;
    int   zero_gain_steps = 0;
    int   cycle_count     = 0;
    int   tilt_walk       = 0;

    // Filter state and register copies of the expected behavior, kept in 64 bits.
    longint angle_est;
    longint bias_est;
    longint cov[4];
    longint dt_q32;
    longint angle_noise_q30;
    longint bias_noise_q30;
    longint meas_noise_q30;

    tilt_angle_kalman_filter_unit u_dut (
        .clk            (clk),
        .rst_n          (rst_n),
        .sample_valid   (sample_valid),
        .sample_ready   (sample_ready),
        .measured_angle (measured_angle),
        .gyro_rate      (gyro_rate),
        .result_valid   (result_valid),
        .result_ready   (result_ready),
        .filtered_angle (filtered_angle),
        .corrected_rate (corrected_rate),
        .cfg_valid      (cfg_valid),
        .cfg_ready      (cfg_ready),
        .cfg_index      (cfg_index),
        .cfg_data       (cfg_data)
    );

    always #2 clk = ~clk;

    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
    end

    // ------------------------------------------------------------------
    // Fixed-point filter used to predict every result.
    // ------------------------------------------------------------------

    function automatic longint clamp_s32(longint v);
        if (v > longint'(S32_MAX))
        begin
            return longint'(S32_MAX);
        end
        if (v < longint'(S32_MIN))
        begin
            return longint'(S32_MIN);
        end
        return v;
    endfunction

    // Product shifted right by sh, rounded to nearest with ties away from zero.
    // The magnitudes multiply in 64 unsigned bits, which every operand pair fits.
    function automatic longint round_mul(longint a, longint b, int sh);
        logic                 neg;
        longint unsigned      ma;
        longint unsigned      mb;
        longint unsigned      p;
        neg = (a < 0) != (b < 0);
        ma  = (a < 0) ? -a : a;
        mb  = (b < 0) ? -b : b;
        p   = ma * mb;
        p   = (p + (64'd1 << (sh - 1))) >> sh;
        return neg ? -longint'(p) : longint'(p);
    endfunction

    // Q2.30 gain: numerator scaled by 2^30 over the innovation variance, truncated.
    function automatic longint gain_q30(longint num, longint innov_var);
        if (innov_var <= 0)
        begin
            return 0;
        end
        return clamp_s32((num * 64'sd1073741824) / innov_var);
    endfunction

    function automatic result_t filter_expected_result(sample_t s);
        longint  meas;
        longint  gyro;
        longint  ang;
        longint  err;
        longint  d0;
        longint  d1;
        longint  d3;
        longint  p00;
        longint  p01;
        longint  p10;
        longint  p11;
        longint  innov_var;
        longint  k0;
        longint  k1;
        longint  rate_out;
        result_t r;
        meas = longint'(s.angle);
        gyro = longint'(s.rate);

        // Prediction: integrate the bias-corrected rate over one sample period.
        ang = clamp_s32(angle_est + round_mul(gyro - bias_est, dt_q32, 32));
        err = meas - ang;

        // Covariance derivative terms saturate before they are scaled by the period.
        d0  = clamp_s32(angle_noise_q30 - cov[1] - cov[2]);
        d1  = clamp_s32(-cov[3]);
        d3  = clamp_s32(bias_noise_q30);
        p00 = clamp_s32(cov[0] + round_mul(d0, dt_q32, 32));
        p01 = clamp_s32(cov[1] + round_mul(d1, dt_q32, 32));
        p10 = clamp_s32(cov[2] + round_mul(d1, dt_q32, 32));
        p11 = clamp_s32(cov[3] + round_mul(d3, dt_q32, 32));

        // A non-positive innovation variance leaves both gains at zero.
        innov_var = meas_noise_q30 + p00;
        if (innov_var <= 0)
        begin
            zero_gain_steps++;
        end
        k0 = gain_q30(p00, innov_var);
        k1 = gain_q30(p10, innov_var);

        cov[0] = clamp_s32(p00 - round_mul(k0, p00, 30));
        cov[1] = clamp_s32(p01 - round_mul(k0, p01, 30));
        cov[2] = clamp_s32(p10 - round_mul(k1, p00, 30));
        cov[3] = clamp_s32(p11 - round_mul(k1, p01, 30));

        angle_est = clamp_s32(ang + round_mul(k0, err, 30));
        bias_est  = clamp_s32(bias_est + round_mul(k1, err, 30));
        rate_out  = clamp_s32(gyro - bias_est);

        r.filtered  = angle_est[DATA_W-1:0];
        r.corrected = rate_out[DATA_W-1:0];
        return r;
    endfunction

    task automatic reset_filter_state();
        dt_q32          = longint'(RST_SAMPLE_PERIOD);
        angle_noise_q30 = longint'(RST_ANGLE_NOISE);
        bias_noise_q30  = longint'(RST_BIAS_NOISE);
        meas_noise_q30  = longint'(RST_MEASURE_NOISE);
        angle_est       = 0;
        bias_est        = 0;
        cov[0]          = longint'(Q30_ONE);
        cov[1]          = 0;
        cov[2]          = 0;
        cov[3]          = longint'(Q30_ONE);
    endtask

    // One line per mismatch; printing stops after a while but counting goes on.
    task automatic report_mismatch(string what, logic [DATA_W-1:0] got,
                                   logic [DATA_W-1:0] want);
        if (error_count < MAX_PRINTED)
        begin
            $display("ERROR at result %0d: %s, got %h, expected %h",
                     results_checked, what, got, want);
        end
        error_count++;
    endtask

    // ------------------------------------------------------------------
    // Sample driver. A new request is put on the bus only when the bus is free
    // or the current one is taken at this edge, so valid never drops early and
    // the payload holds until acceptance. The expected result is computed at
    // the edge where the request is accepted.
    // ------------------------------------------------------------------
    always @(posedge clk)
    begin : sample_driver
        sample_t next_sample;
        sample_t taken;
        if (!rst_n)
        begin
            sample_valid <= 1'b0;
        end
        else
        begin
            if (sample_valid && sample_ready)
            begin
                taken.angle = measured_angle;
                taken.rate  = gyro_rate;
                expected_outputs.push_back(filter_expected_result(taken));
                samples_sent++;
            end
            if (!sample_valid || sample_ready)
            begin
                if (pending_samples.size() > 0 && $urandom_range(99) >= send_gap_pct)
                begin
                    next_sample = pending_samples.pop_front();
                    sample_valid   <= 1'b1;
                    measured_angle <= next_sample.angle;
                    gyro_rate      <= next_sample.rate;
                end
                else
                begin
                    sample_valid <= 1'b0;
                end
            end
        end
    end

    // ------------------------------------------------------------------
    // Result monitor. Every accepted result request is compared field by field
    // with the oldest expectation. Ready is withdrawn at random, and for the
    // whole of the long hold-off.
    // ------------------------------------------------------------------
    always @(posedge clk)
    begin : result_monitor
        result_t want;
        if (!rst_n)
        begin
            result_ready <= 1'b0;
        end
        else
        begin
            if (result_valid && result_ready)
            begin
                if (expected_outputs.size() == 0)
                begin
                    report_mismatch("result with no sample pending", filtered_angle, '0);
                end
                else
                begin
                    want = expected_outputs.pop_front();
                    if (filtered_angle !== want.filtered)
                    begin
                        report_mismatch("filtered_angle", filtered_angle, want.filtered);
                    end
                    if (corrected_rate !== want.corrected)
                    begin
                        report_mismatch("corrected_rate", corrected_rate, want.corrected);
                    end
                end
                results_checked++;
            end
            result_ready <= !hold_active && ($urandom_range(99) >= recv_stall_pct);
        end
    end

    // Long receiver hold-off, timed in its own process. The sender keeps offering
    // requests meanwhile, so the output register and the sample in flight fill up
    // and the block has to stall its input.
    initial
    begin
        while (!hold_request)
        begin
            @(posedge clk);
        end
        @(posedge clk);
        hold_active <= 1'b1;
        repeat (HOLD_CYCLES) @(posedge clk);
        hold_active <= 1'b0;
    end

    // Watchdog: a hang anywhere ends the run as a failure.
    initial
    begin
        while (cycle_count < CYCLE_LIMIT)
        begin
            @(posedge clk);
        end
        $display("Timeout after %0d cycles, %0d results still expected",
                 cycle_count, expected_outputs.size());
        $display("DONE: errors detected");
        $finish;
    end

    // ------------------------------------------------------------------
    // Stimulus helpers.
    // ------------------------------------------------------------------

    // A register write request; the expected filter takes the value at the edge
    // where the request is accepted. Indexes past the last register change nothing.
    task automatic write_register(logic [CFG_IDX_W-1:0] idx, logic [DATA_W-1:0] data);
        @(posedge clk);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= data;
        do
        begin
            @(posedge clk);
        end
        while (!cfg_ready);
        case (idx)
            REG_SAMPLE_PERIOD: dt_q32          = longint'(data);
            REG_ANGLE_NOISE:   angle_noise_q30 = longint'(data);
            REG_BIAS_NOISE:    bias_noise_q30  = longint'(data);
            REG_MEASURE_NOISE: meas_noise_q30  = longint'(data);
            default:           ;
        endcase
        register_writes++;
        cfg_valid <= 1'b0;
    endtask

    // Registers change only while the block is idle: every sample accepted,
    // every result back, and then the length of a whole sample and more. The
    // queues are looked at on the falling edge, once the driver's updates of
    // the rising edge have all landed.
    task automatic wait_until_drained();
        while (pending_samples.size() != 0 || sample_valid || expected_outputs.size() != 0)
        begin
            @(negedge clk);
        end
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    task automatic set_idling(int send_pct, int recv_pct);
        @(posedge clk);
        send_gap_pct   <= send_pct;
        recv_stall_pct <= recv_pct;
    endtask

    task automatic queue_sample(logic signed [DATA_W-1:0] angle,
                                logic signed [DATA_W-1:0] rate);
        sample_t s;
        s.angle = angle;
        s.rate  = rate;
        pending_samples.push_back(s);
    endtask

    function automatic logic signed [DATA_W-1:0] corner_value();
        case ($urandom_range(4))
            0:       return S32_MIN;
            1:       return S32_MAX;
            2:       return '0;
            3:       return -32'sd1;
            default: return 32'sd1;
        endcase
    endfunction

    // Most samples follow a slowly wandering tilt with measurement noise and a
    // plausible gyro rate, so the filter settles and tracks. The rest are full
    // range values and corner values that push the arithmetic into saturation.
    task automatic queue_random_samples(int count);
        logic signed [DATA_W-1:0] angle;
        logic signed [DATA_W-1:0] rate;
        for (int i = 0; i < count; i++)
        begin
            tilt_walk += int'($urandom_range(2 * DEG_ONE)) - DEG_ONE;
            if (tilt_walk > DEG_90)
            begin
                tilt_walk = DEG_90;
            end
            if (tilt_walk < -DEG_90)
            begin
                tilt_walk = -DEG_90;
            end
            angle = tilt_walk + int'($urandom_range(6 * DEG_ONE)) - 3 * DEG_ONE;
            rate  = int'($urandom_range(2 * RATE_SPAN)) - RATE_SPAN;
            case ($urandom_range(9))
                0:
                begin
                    angle = $urandom;
                    rate  = $urandom;
                end
                1:
                begin
                    angle = corner_value();
                    rate  = corner_value();
                end
                2:       rate = $urandom;
                default: ;
            endcase
            queue_sample(angle, rate);
        end
    endtask

    // A fresh register setting: mostly realistic periods and noises, now and then
    // tiny periods or full range values, plus a write to an unused index.
    task automatic write_random_config();
        logic [DATA_W-1:0] v;
        case ($urandom_range(3))
            0:       v = $urandom;
            1:       v = $urandom_range(1000, 1);
            default: v = $urandom_range(85899345, 429497);
        endcase
        write_register(REG_SAMPLE_PERIOD, v);
        v = ($urandom_range(4) == 0) ? $urandom : $urandom_range(32'h0800_0000, 0);
        write_register(REG_ANGLE_NOISE, v);
        v = ($urandom_range(4) == 0) ? $urandom : $urandom_range(32'h0800_0000, 0);
        write_register(REG_BIAS_NOISE, v);
        v = ($urandom_range(4) == 0) ? $urandom : $urandom_range(32'h8000_0000, 32'h0100_0000);
        write_register(REG_MEASURE_NOISE, v);
        write_register(CFG_IDX_W'($urandom_range(REG_INDEX_TOP, REG_COUNT)), $urandom);
    endtask

    // ------------------------------------------------------------------
    // Main sequence.
    // ------------------------------------------------------------------
    initial
    begin
        reset_filter_state();
        repeat (RESET_CYCLES) @(posedge clk);
        rst_n <= 1'b1;
        set_idling(34, 82);

        // Field extremes and a few ordinary angles at the reset register values.
        queue_sample('0, '0);
        queue_sample(S32_MAX, S32_MAX);
        queue_sample(S32_MIN, S32_MIN);
        queue_sample(S32_MAX, S32_MIN);
        queue_sample(S32_MIN, S32_MAX);
        queue_sample(-32'sd1, 32'sd1);
        queue_sample(32'sd1, -32'sd1);
        queue_sample(DEG_90, '0);
        queue_sample(-DEG_90, 32'sd655360);
        queue_sample('0, S32_MAX);
        queue_sample('0, S32_MIN);
        queue_sample(32'sd2949120, -32'sd6553600);
        wait_until_drained();

        // Zero sample period: no prediction, only the correction moves the state.
        write_register(REG_SAMPLE_PERIOD, '0);
        queue_sample(32'sd655360, 32'sd3276800);
        queue_sample(32'sd655360, 32'sd3276800);
        queue_sample(-DEG_90, S32_MAX);
        queue_sample(S32_MAX, '0);
        wait_until_drained();

        // Smallest period, no process noise and no measurement noise. The first
        // sample drives P00 to zero, so the following ones see a zero innovation
        // variance and both gains vanish. The unused top index must be ignored.
        write_register(REG_SAMPLE_PERIOD, 32'd1);
        write_register(REG_ANGLE_NOISE, '0);
        write_register(REG_BIAS_NOISE, '0);
        write_register(REG_MEASURE_NOISE, '0);
        write_register(REG_INDEX_TOP, '1);
        queue_sample(DEG_90, 32'sd655360);
        queue_sample(-DEG_90, -32'sd655360);
        queue_sample(S32_MIN, S32_MAX);
        queue_sample('0, '0);
        queue_sample(32'sd1, 32'sd1);
        wait_until_drained();

        // Every register at its top value: saturation all along the path.
        write_register(REG_SAMPLE_PERIOD, '1);
        write_register(REG_ANGLE_NOISE, '1);
        write_register(REG_BIAS_NOISE, '1);
        write_register(REG_MEASURE_NOISE, '1);
        queue_sample(S32_MAX, S32_MIN);
        queue_sample(S32_MIN, S32_MAX);
        queue_sample('0, 32'sd6553600);
        queue_sample(DEG_90, '0);
        wait_until_drained();

        write_register(REG_SAMPLE_PERIOD, RST_SAMPLE_PERIOD);
        write_register(REG_ANGLE_NOISE, RST_ANGLE_NOISE);
        write_register(REG_BIAS_NOISE, RST_BIAS_NOISE);
        write_register(REG_MEASURE_NOISE, RST_MEASURE_NOISE);

        // Random phases: the first third with a slow receiver, the second with a
        // slow sender, the last with no idling, where the long hold-off starts.
        // The first phase keeps the default registers.
        for (int phase = 0; phase < NUM_PHASES; phase++)
        begin
            if (phase == NUM_PHASES / 3)
            begin
                set_idling(82, 34);
            end
            else if (phase == 2 * NUM_PHASES / 3)
            begin
                set_idling(0, 0);
                hold_request = 1'b1;
            end
            if (phase != 0)
            begin
                write_random_config();
            end
            queue_random_samples(ITEMS_PER_PHASE);
            wait_until_drained();
        end

        $display("Covered %0d samples and %0d results over %0d register writes,",
                 samples_sent, results_checked, register_writes);
        $display("with zero gains on %0d samples, under both idling patterns and a hold-off.",
                 zero_gain_steps);
        if (error_count == 0)
        begin
            $display("DONE: 0 errors");
        end
        else
        begin
            $display("DONE: errors detected");
        end
        $finish;
    end

endmodule
